>>> design/mnas_pkg.sv
// ----------------------------------------------------------------------------
// Mesh smoothing package
// Shared constants, codes and types for the neighbour-average smoothing block.
// ----------------------------------------------------------------------------
package mnas_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_DEGREE   = 8;

    localparam int OPC_W   = 3;
    localparam int VTX_W   = 10;
    localparam int SLOT_W  = 3;
    localparam int CNT_W   = 4;
    localparam int COORD_W = 32;
    localparam int PASS_W  = 8;
    localparam int VCNT_W  = 11;

    typedef enum logic [OPC_W-1:0] {
        OPC_LOAD_POS = 3'd0,
        OPC_LOAD_NB  = 3'd1,
        OPC_SET_CNT  = 3'd2,
        OPC_START    = 3'd3,
        OPC_READ     = 3'd4
    } opcode_t;

    typedef enum logic {
        CFG_PASS_COUNT   = 1'b0,
        CFG_VERTEX_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_LOAD_POS,
        KIND_LOAD_NB,
        KIND_SET_CNT,
        KIND_START,
        KIND_READ,
        KIND_REJECT
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic [VTX_W-1:0]           vertex;
        logic [SLOT_W-1:0]          slot;
        logic [VTX_W-1:0]           neighbour;
        logic [CNT_W-1:0]           count;
        logic [COORD_W-1:0]         x;
        logic [COORD_W-1:0]         y;
        logic [COORD_W-1:0]         z;
    } item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_VTX,
        ST_VTX_CNT,
        ST_CARRY_WR,
        ST_NB_RD,
        ST_NB_POS,
        ST_NB_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } back_state_t;

endpackage

>>> design/mnas_front.sv
// ----------------------------------------------------------------------------
// Mesh smoothing front end
// Accepts beats, checks ranges, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
module mnas_front import mnas_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE,
    localparam int NW          = $clog2(MAX_VERTICES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [NW-1:0]        used_count,
    input  logic                 clear_busy,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OPC_W-1:0]     s_opcode,
    input  logic [VTX_W-1:0]     s_vertex,
    input  logic [SLOT_W-1:0]    s_slot,
    input  logic [VTX_W-1:0]     s_neighbour,
    input  logic [CNT_W-1:0]     s_count,
    input  logic [COORD_W-1:0]   s_coord_x,
    input  logic [COORD_W-1:0]   s_coord_y,
    input  logic [COORD_W-1:0]   s_coord_z,
    output logic                 head_valid,
    output item_t                head,
    input  logic                 pop
);

    item_t       q_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;
    item_t       item;
    logic        vtx_ok, nb_ok, push;

    always_comb begin
        vtx_ok = 32'(s_vertex) < 32'(used_count);
        nb_ok  = (32'(s_neighbour) < 32'(used_count)) && (32'(s_slot) < MAX_DEGREE);
        item           = '0;
        item.vertex    = s_vertex;
        item.slot      = s_slot;
        item.neighbour = s_neighbour;
        item.count     = s_count;
        item.x         = s_coord_x;
        item.y         = s_coord_y;
        item.z         = s_coord_z;
        unique case (opcode_t'(s_opcode))
            OPC_LOAD_POS: item.kind = vtx_ok ? KIND_LOAD_POS : KIND_REJECT;
            OPC_LOAD_NB:  item.kind = (vtx_ok && nb_ok) ? KIND_LOAD_NB : KIND_REJECT;
            OPC_SET_CNT:  item.kind = (vtx_ok && (32'(s_count) <= MAX_DEGREE)) ?
                                      KIND_SET_CNT : KIND_REJECT;
            OPC_START:    item.kind = KIND_START;
            OPC_READ:     item.kind = vtx_ok ? KIND_READ : KIND_REJECT;
            default:      item.kind = KIND_REJECT;
        endcase
    end

    assign s_ready    = !clear_busy && (fill_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign head_valid = fill_reg != 2'd0;
    assign head       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> design/mnas_divider.sv
// ----------------------------------------------------------------------------
// Mesh smoothing divider
// Three-lane restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module mnas_divider import mnas_pkg::*; #(
    parameter int SUM_W = 36,
    parameter int DIV_W = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend [3],
    input  logic [DIV_W-1:0]         divisor,
    output logic                     busy,
    output logic [COORD_W-1:0]       quotient [3]
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  mag_reg [3];
    logic [DIV_W-1:0]  rem_reg [3];
    logic              neg_reg [3];
    logic [DIV_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [DIV_W:0]    rem_sh [3];
    logic              ge [3];
    logic [SUM_W-1:0]  signed_q [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rem_sh[i]   = {rem_reg[i], mag_reg[i][SUM_W-1]};
            ge[i]       = rem_sh[i] >= {1'b0, div_reg};
            signed_q[i] = neg_reg[i] ? (~mag_reg[i] + SUM_W'(1)) : mag_reg[i];
            quotient[i] = signed_q[i][COORD_W-1:0];
        end
    end

    assign busy = busy_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= dividend[i][SUM_W-1];
                mag_reg[i] <= dividend[i][SUM_W-1] ? SUM_W'(-dividend[i])
                                                   : SUM_W'(dividend[i]);
                rem_reg[i] <= '0;
            end
        end else if (busy_reg) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= {mag_reg[i][SUM_W-2:0], ge[i]};
                rem_reg[i] <= ge[i] ? DIV_W'(rem_sh[i] - {1'b0, div_reg})
                                    : DIV_W'(rem_sh[i]);
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/mnas_back.sv
// ----------------------------------------------------------------------------
// Mesh smoothing back end
// Owns the position, neighbour and count stores and runs the smoothing passes.
// ----------------------------------------------------------------------------
module mnas_back import mnas_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE,
    localparam int NW          = $clog2(MAX_VERTICES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [NW-1:0]        used_count,
    input  logic [PASS_W-1:0]    pass_count,
    output logic                 clear_busy,
    input  logic                 head_valid,
    input  item_t                head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COORD_W-1:0]   m_out_x,
    output logic [COORD_W-1:0]   m_out_y,
    output logic [COORD_W-1:0]   m_out_z,
    output logic                 m_status
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_DEGREE + 1);
    localparam int WAW   = $clog2(2 * MAX_VERTICES);
    localparam int TW    = $clog2(MAX_VERTICES * MAX_DEGREE) > 0 ?
                           $clog2(MAX_VERTICES * MAX_DEGREE) : 1;
    localparam int SUM_W = COORD_W + CW;
    localparam int POS_W = 3 * COORD_W;

    // Stores.
    logic [POS_W-1:0] orig_mem [MAX_VERTICES];
    logic [POS_W-1:0] work_mem [2 * MAX_VERTICES];
    logic [VW-1:0]    tab_mem  [MAX_VERTICES * MAX_DEGREE];
    logic [CW-1:0]    cnt_mem  [MAX_VERTICES];

    logic [POS_W-1:0] orig_rd_reg, work_rd_reg;
    logic [VW-1:0]    tab_rd_reg;
    logic [CW-1:0]    cnt_rd_reg;

    logic             orig_we, work_we, tab_we, cnt_we;
    logic [VW-1:0]    orig_wa, orig_ra, cnt_wa, cnt_ra;
    logic [WAW-1:0]   work_wa, work_ra;
    logic [TW-1:0]    tab_wa, tab_ra;
    logic [POS_W-1:0] orig_wd, work_wd;
    logic [VW-1:0]    tab_wd;
    logic [CW-1:0]    cnt_wd;

    back_state_t      state_reg, state_next;
    logic [VW-1:0]    v_reg, v_next;
    logic [CW-1:0]    k_reg, k_next, cnt_reg, cnt_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic             bank_reg, bank_next;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] sum_next [3];

    logic             m_valid_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic             status_reg;
    logic             out_load, out_status;
    logic [POS_W-1:0] out_pos;
    logic             out_free;

    logic             div_start, div_busy;
    logic [COORD_W-1:0] quot [3];

    logic [VW-1:0]    hv, hn;
    logic             last_v, last_pass, carry;
    logic [COORD_W-1:0] nb_c [3];

    mnas_divider #(
        .SUM_W (SUM_W),
        .DIV_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign clear_busy = state_reg == ST_CLEAR;
    assign hv         = VW'(head.vertex);
    assign hn         = VW'(head.neighbour);
    assign last_v     = v_reg == VW'(MAX_VERTICES - 1);
    assign last_pass  = ({1'b0, pass_reg} + 9'd1) == {1'b0, pass_count};
    assign carry      = (32'(v_reg) >= 32'(used_count)) || (cnt_rd_reg == '0);
    assign nb_c[0]    = work_rd_reg[POS_W-1 -: COORD_W];
    assign nb_c[1]    = work_rd_reg[2*COORD_W-1 -: COORD_W];
    assign nb_c[2]    = work_rd_reg[COORD_W-1:0];

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (last_v) state_next = ST_IDLE;
            ST_IDLE: begin
                if (head_valid && out_free) begin
                    if (head.kind == KIND_READ) begin
                        state_next = ST_READ_WAIT;
                    end else if (head.kind == KIND_START) begin
                        state_next = ST_COPY_RD;
                    end
                end
            end
            ST_READ_WAIT: state_next = ST_IDLE;
            ST_COPY_RD:   state_next = ST_COPY_WR;
            ST_COPY_WR: begin
                if (last_v) begin
                    state_next = (pass_count == '0) ? ST_DONE : ST_VTX;
                end else begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_VTX:       state_next = ST_VTX_CNT;
            ST_VTX_CNT:   state_next = carry ? ST_CARRY_WR : ST_NB_RD;
            ST_CARRY_WR:  state_next = (last_v && last_pass) ? ST_DONE : ST_VTX;
            ST_NB_RD:     state_next = ST_NB_POS;
            ST_NB_POS:    state_next = ST_NB_ACC;
            ST_NB_ACC:    state_next = ((k_reg + CW'(1)) == cnt_reg) ? ST_DIV_GO : ST_NB_RD;
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (!div_busy) begin
                    state_next = (last_v && last_pass) ? ST_DONE : ST_VTX;
                end
            end
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        pop        = 1'b0;
        orig_we    = 1'b0;
        orig_wa    = hv;
        orig_wd    = {head.x, head.y, head.z};
        orig_ra    = v_reg;
        work_we    = 1'b0;
        work_wa    = bank_reg ? WAW'(v_reg) : WAW'(MAX_VERTICES) + WAW'(v_reg);
        work_wd    = work_rd_reg;
        work_ra    = bank_reg ? WAW'(MAX_VERTICES) + WAW'(v_reg) : WAW'(v_reg);
        tab_we     = 1'b0;
        tab_wa     = TW'(hv) * TW'(MAX_DEGREE) + TW'(head.slot);
        tab_wd     = hn;
        tab_ra     = TW'(v_reg) * TW'(MAX_DEGREE) + TW'(k_reg);
        cnt_we     = 1'b0;
        cnt_wa     = hv;
        cnt_wd     = CW'(head.count);
        cnt_ra     = v_reg;
        out_load   = 1'b0;
        out_status = 1'b0;
        out_pos    = '0;
        div_start  = 1'b0;
        v_next     = v_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        bank_next  = bank_reg;
        for (int i = 0; i < 3; i++) begin
            sum_next[i] = sum_reg[i];
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cnt_we = 1'b1;
                cnt_wa = v_reg;
                cnt_wd = '0;
                v_next = v_reg + VW'(1);
            end
            ST_IDLE: begin
                if (head_valid && out_free) begin
                    pop = 1'b1;
                    work_ra = bank_reg ? WAW'(MAX_VERTICES) + WAW'(hv) : WAW'(hv);
                    unique case (head.kind)
                        KIND_LOAD_POS: begin
                            orig_we  = 1'b1;
                            out_load = 1'b1;
                        end
                        KIND_LOAD_NB: begin
                            tab_we   = 1'b1;
                            out_load = 1'b1;
                        end
                        KIND_SET_CNT: begin
                            cnt_we   = 1'b1;
                            out_load = 1'b1;
                        end
                        KIND_START:    v_next = '0;
                        KIND_READ:     ;
                        default: begin
                            out_load   = 1'b1;
                            out_status = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_WAIT: begin
                out_load = 1'b1;
                out_pos  = work_rd_reg;
            end
            ST_COPY_RD: ;
            ST_COPY_WR: begin
                work_we = 1'b1;
                work_wa = WAW'(v_reg);
                work_wd = orig_rd_reg;
                v_next  = last_v ? '0 : v_reg + VW'(1);
                if (last_v) begin
                    bank_next = 1'b0;
                    pass_next = '0;
                end
            end
            ST_VTX: ;
            ST_VTX_CNT: begin
                cnt_next = cnt_rd_reg;
                k_next   = '0;
                for (int i = 0; i < 3; i++) begin
                    sum_next[i] = '0;
                end
            end
            ST_NB_RD: ;
            ST_NB_POS: begin
                work_ra = bank_reg ? WAW'(MAX_VERTICES) + WAW'(tab_rd_reg)
                                   : WAW'(tab_rd_reg);
            end
            ST_NB_ACC: begin
                k_next = k_reg + CW'(1);
                for (int i = 0; i < 3; i++) begin
                    sum_next[i] = sum_reg[i] + {{CW{nb_c[i][COORD_W-1]}}, nb_c[i]};
                end
            end
            ST_DIV_GO:  div_start = 1'b1;
            ST_CARRY_WR, ST_DIV_WAIT: begin
                if (state_reg == ST_CARRY_WR || !div_busy) begin
                    work_we = 1'b1;
                    if (state_reg == ST_DIV_WAIT) begin
                        work_wd = {quot[0], quot[1], quot[2]};
                    end
                    v_next = last_v ? '0 : v_reg + VW'(1);
                    if (last_v) begin
                        bank_next = ~bank_reg;
                        pass_next = pass_reg + PASS_W'(1);
                    end
                end
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (orig_we) begin
            orig_mem[orig_wa] <= orig_wd;
        end
        orig_rd_reg <= orig_mem[orig_ra];
    end

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work_mem[work_wa] <= work_wd;
        end
        work_rd_reg <= work_mem[work_ra];
    end

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            tab_mem[tab_wa] <= tab_wd;
        end
        tab_rd_reg <= tab_mem[tab_ra];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd_reg <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        pass_reg <= pass_next;
        for (int i = 0; i < 3; i++) begin
            sum_reg[i] <= sum_next[i];
        end
        if (out_load) begin
            out_x_reg  <= out_pos[POS_W-1 -: COORD_W];
            out_y_reg  <= out_pos[2*COORD_W-1 -: COORD_W];
            out_z_reg  <= out_pos[COORD_W-1:0];
            status_reg <= out_status;
        end
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            v_reg       <= '0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v_reg     <= v_next;
            bank_reg  <= bank_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_out_x  = out_x_reg;
    assign m_out_y  = out_y_reg;
    assign m_out_z  = out_z_reg;
    assign m_status = status_reg;

endmodule

>>> design/mesh_neighbour_average_smoothing.sv
// ----------------------------------------------------------------------------
// Mesh neighbour-average smoothing
// Uniform Laplacian smoothing of Q16.16 vertex positions with double buffering.
// ----------------------------------------------------------------------------
// After reset the neighbour counts of all MAX_VERTICES slots are cleared, and
// no beat is taken meanwhile. Load, count and read beats are accepted one per
// cycle while the two-entry queue has room, and each returns one result beat;
// a read passes a read-wait state in the back end. A start beat copies all
// MAX_VERTICES originals (a read and a write state each), then runs pass_count
// passes over every vertex slot: a carried vertex passes the vertex, count and
// carry-write states; one with c neighbours passes vertex and count, then read,
// position and accumulate per neighbour, then the serial divider: one quotient
// bit per cycle over 32 + clog2(MAX_DEGREE + 1) bits. The three coordinates are
// worked in parallel; the single position read port sets the neighbour loop rate.
module mesh_neighbour_average_smoothing import mnas_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [VCNT_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OPC_W-1:0]     s_opcode,
    input  logic [VTX_W-1:0]     s_vertex,
    input  logic [SLOT_W-1:0]    s_slot,
    input  logic [VTX_W-1:0]     s_neighbour,
    input  logic [CNT_W-1:0]     s_count,
    input  logic [COORD_W-1:0]   s_coord_x,
    input  logic [COORD_W-1:0]   s_coord_y,
    input  logic [COORD_W-1:0]   s_coord_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COORD_W-1:0]   m_out_x,
    output logic [COORD_W-1:0]   m_out_y,
    output logic [COORD_W-1:0]   m_out_z,
    output logic                 m_status
);

    localparam int NW = $clog2(MAX_VERTICES + 1);

    logic [PASS_W-1:0] pass_count_reg;
    logic [VCNT_W-1:0] vertex_count_reg;
    logic [NW-1:0]     used_count;
    logic              clear_busy, head_valid, pop;
    item_t             head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_count_reg   <= PASS_W'(1);
            vertex_count_reg <= VCNT_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PASS_COUNT:   pass_count_reg   <= cfg_wdata[PASS_W-1:0];
                CFG_VERTEX_COUNT: vertex_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Vertices in use are capped at the store depth.
    assign used_count = (32'(vertex_count_reg) < 32'(MAX_VERTICES)) ?
                        NW'(vertex_count_reg) : NW'(MAX_VERTICES);

    mnas_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .used_count  (used_count),
        .clear_busy  (clear_busy),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_vertex    (s_vertex),
        .s_slot      (s_slot),
        .s_neighbour (s_neighbour),
        .s_count     (s_count),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_coord_z   (s_coord_z),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop)
    );

    mnas_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .used_count (used_count),
        .pass_count (pass_count_reg),
        .clear_busy (clear_busy),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_out_z    (m_out_z),
        .m_status   (m_status)
    );

endmodule

>>> tb/mesh_neighbour_average_smoothing_tb.sv
// ----------------------------------------------------------------------------
// Mesh neighbour-average smoothing testbench
// Loads small meshes, runs smoothing passes under several register settings and
// compares every result beat against an in-bench model of the averaging passes.
// ----------------------------------------------------------------------------
module mesh_neighbour_average_smoothing_tb;
    import mnas_pkg::*;

    localparam int MAXV  = DEF_MAX_VERTICES;
    localparam int MAXD  = DEF_MAX_DEGREE;
    localparam int LIMIT = 20000000;
    localparam logic [OPC_W-1:0] OPC_UNUSED_LO = 3'd5;
    localparam logic [OPC_W-1:0] OPC_UNUSED_HI = 3'd7;

    typedef struct {
        logic [OPC_W-1:0]   op;
        logic [VTX_W-1:0]   vtx;
        logic [SLOT_W-1:0]  slot;
        logic [VTX_W-1:0]   nb;
        logic [CNT_W-1:0]   cnt;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } beat_t;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               st;
    } result_t;

    class smoothing_scoreboard;
        result_t            pending[$];
        logic [COORD_W-1:0] orig[3*MAXV];
        bit                 orig_ok[MAXV];
        logic [COORD_W-1:0] work[2][3*MAXV];
        bit                 work_ok[2][MAXV];
        logic [VTX_W-1:0]   nbr[MAXV*MAXD];
        bit                 nbr_ok[MAXV*MAXD];
        logic [CNT_W-1:0]   deg[MAXV];
        bit                 bank;
        int unsigned        passes;
        int unsigned        vcount;
        int unsigned        busy_cycles;
        int                 errors;

        function new();
            foreach (orig[i]) orig[i] = '0;
            foreach (work[b, i]) work[b][i] = '0;
            foreach (nbr[i]) nbr[i] = '0;
            foreach (deg[i]) deg[i] = '0;
            bank   = 0;
            passes = 1;
            vcount = 1;
            errors = 0;
        endfunction

        function int unsigned used();
            return (vcount < MAXV) ? vcount : MAXV;
        endfunction

        function int unsigned filled_slots(int v);
            int unsigned k;
            k = 0;
            while (k < MAXD && nbr_ok[v*MAXD+k]) k++;
            return k;
        endfunction

        // A vertex result is only trusted where every position it draws on was loaded.
        function void smooth_pass(bit src);
            int unsigned n, c, nb;
            bit          ok;
            longint      sum;
            n = used();
            for (int v = 0; v < MAXV; v++) begin
                c = deg[v];
                if (v >= n || c == 0) begin
                    for (int k = 0; k < 3; k++) work[!src][3*v+k] = work[src][3*v+k];
                    work_ok[!src][v] = work_ok[src][v];
                end else begin
                    ok = 1;
                    for (int k = 0; k < 3; k++) begin
                        sum = 0;
                        for (int j = 0; j < c; j++) begin
                            nb  = nbr[v*MAXD+j];
                            ok  = ok & nbr_ok[v*MAXD+j] & work_ok[src][nb];
                            sum += longint'(signed'(work[src][3*nb+k]));
                        end
                        work[!src][3*v+k] = COORD_W'(sum / longint'(int'(c)));
                    end
                    work_ok[!src][v] = ok;
                end
            end
        endfunction

        function void note(beat_t b);
            result_t     r;
            int unsigned n, per_pass;
            n = used();
            r = '{'0, '0, '0, 1'b0};
            case (b.op)
                OPC_LOAD_POS: begin
                    if (b.vtx >= n) r.st = 1;
                    else begin
                        orig[3*b.vtx]   = b.x;
                        orig[3*b.vtx+1] = b.y;
                        orig[3*b.vtx+2] = b.z;
                        orig_ok[b.vtx]  = 1;
                    end
                end
                OPC_LOAD_NB: begin
                    if (b.vtx >= n || b.nb >= n || b.slot >= MAXD) r.st = 1;
                    else begin
                        nbr[b.vtx*MAXD+b.slot]    = b.nb;
                        nbr_ok[b.vtx*MAXD+b.slot] = 1;
                    end
                end
                OPC_SET_CNT: begin
                    if (b.vtx >= n || b.cnt > MAXD) r.st = 1;
                    else deg[b.vtx] = b.cnt;
                end
                OPC_START: begin
                    work[0]    = orig;
                    work_ok[0] = orig_ok;
                    bank       = 0;
                    per_pass   = 0;
                    for (int v = 0; v < MAXV; v++)
                        per_pass += (v < n && deg[v] != 0) ? 3*deg[v] + 45 : 3;
                    busy_cycles = 2*MAXV + passes*per_pass + 64;
                    for (int p = 0; p < passes; p++) begin
                        smooth_pass(bank);
                        bank = !bank;
                    end
                end
                OPC_READ: begin
                    if (b.vtx >= n) r.st = 1;
                    else begin
                        r.x = work[bank][3*b.vtx];
                        r.y = work[bank][3*b.vtx+1];
                        r.z = work[bank][3*b.vtx+2];
                    end
                end
                default: r.st = 1;
            endcase
            pending.push_back(r);
        endfunction

        function void check(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $display("%0t: result beat with nothing expected: x=%h y=%h z=%h status=%b",
                         $time, got.x, got.y, got.z, got.st);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
                errors++;
            end
            if (got.st !== want.st) begin
                $display("%0t: status expected %b actual %b", $time, want.st, got.st);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_index;
    logic [VCNT_W-1:0]   cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [OPC_W-1:0]    s_opcode;
    logic [VTX_W-1:0]    s_vertex;
    logic [SLOT_W-1:0]   s_slot;
    logic [VTX_W-1:0]    s_neighbour;
    logic [CNT_W-1:0]    s_count;
    logic [COORD_W-1:0]  s_coord_x;
    logic [COORD_W-1:0]  s_coord_y;
    logic [COORD_W-1:0]  s_coord_z;
    logic                m_valid;
    logic                m_ready;
    logic [COORD_W-1:0]  m_out_x;
    logic [COORD_W-1:0]  m_out_y;
    logic [COORD_W-1:0]  m_out_z;
    logic                m_status;

    smoothing_scoreboard sb;
    longint unsigned     cycle;
    longint unsigned     busy_until;
    int                  ready_hold;
    bit                  s_burst;
    bit                  r_burst;
    int                  sent;

    mesh_neighbour_average_smoothing u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_vertex    (s_vertex),
        .s_slot      (s_slot),
        .s_neighbour (s_neighbour),
        .s_count     (s_count),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_coord_z   (s_coord_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_status    (m_status)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle++;
        if (cycle > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note('{s_opcode, s_vertex, s_slot, s_neighbour, s_count,
                          s_coord_x, s_coord_y, s_coord_z});
                if (s_opcode == OPC_START) busy_until = cycle + sb.busy_cycles;
            end
            if (m_valid && m_ready) begin
                sb.check('{m_out_x, m_out_y, m_out_z, m_status});
                ready_hold = r_burst ? 0 : $urandom_range(0, 15);
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // All driving tasks are entered and left at a falling edge.
    task automatic pause();
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic drive(beat_t b);
        pause();
        s_opcode    <= b.op;
        s_vertex    <= b.vtx;
        s_slot      <= b.slot;
        s_neighbour <= b.nb;
        s_count     <= b.cnt;
        s_coord_x   <= b.x;
        s_coord_y   <= b.y;
        s_coord_z   <= b.z;
        s_valid     <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0 || cycle < busy_until) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(cfg_index_t idx, int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= VCNT_W'(val);
        if (idx == CFG_PASS_COUNT) sb.passes = val & 8'hFF;
        else sb.vcount = val & 11'h7FF;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic beat_t rand_beat();
        beat_t b;
        b.op   = OPC_W'($urandom_range(0, 7));
        b.vtx  = VTX_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15));
        b.slot = SLOT_W'($urandom);
        b.nb   = VTX_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15));
        b.cnt  = CNT_W'($urandom);
        b.x    = rand_coord();
        b.y    = rand_coord();
        b.z    = rand_coord();
        return b;
    endfunction

    function automatic beat_t mk(logic [OPC_W-1:0] op, int unsigned vtx, int unsigned slot = 0,
                                 int unsigned nb = 0, int unsigned cnt = 0);
        beat_t b;
        b      = rand_beat();
        b.op   = op;
        b.vtx  = VTX_W'(vtx);
        b.slot = SLOT_W'(slot);
        b.nb   = VTX_W'(nb);
        b.cnt  = CNT_W'(cnt);
        return b;
    endfunction

    // Keeps random beats away from positions and neighbour slots never loaded.
    function automatic beat_t tidy(beat_t b);
        int unsigned n;
        n = sb.used();
        if (b.op == OPC_SET_CNT && b.vtx < n && b.cnt <= MAXD && b.cnt > sb.filled_slots(b.vtx))
            b.cnt = CNT_W'(sb.filled_slots(b.vtx));
        if (b.op == OPC_READ && b.vtx < n && !sb.work_ok[sb.bank][b.vtx])
            b.op = OPC_UNUSED_HI;
        return b;
    endfunction

    task automatic send(beat_t b);
        if ($urandom_range(0, 6) == 0) drive(tidy(rand_beat()));
        drive(tidy(b));
    endtask

    task automatic mesh_run(int unsigned nv, int unsigned np);
        int unsigned m, d;
        drain();
        s_burst = ($urandom_range(0, 3) == 0);
        r_burst = ($urandom_range(0, 3) == 0);
        cfg_write(CFG_VERTEX_COUNT, nv);
        cfg_write(CFG_PASS_COUNT, np);
        m = (sb.used() < 12) ? sb.used() : 12;
        for (int v = 0; v < m; v++) send(mk(OPC_LOAD_POS, v));
        for (int v = 0; v < m; v++) begin
            d = $urandom_range(0, (m < MAXD) ? m : MAXD);
            for (int k = 0; k < d; k++) send(mk(OPC_LOAD_NB, v, k, $urandom_range(0, m-1)));
            send(mk(OPC_SET_CNT, v, 0, 0, d));
        end
        send(mk(OPC_START, $urandom));
        for (int v = 0; v < m; v++) send(mk(OPC_READ, v));
    endtask

    initial begin
        int unsigned nv, np;
        sb          = new();
        cycle       = 0;
        busy_until  = 0;
        ready_hold  = 0;
        sent        = 0;
        s_burst     = 0;
        r_burst     = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_PASS_COUNT;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_opcode    = OPC_LOAD_POS;
        s_vertex    = '0;
        s_slot      = '0;
        s_neighbour = '0;
        s_count     = '0;
        s_coord_x   = '0;
        s_coord_y   = '0;
        s_coord_z   = '0;
        m_ready     = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, every rejection path, zero passes and stale neighbours.
        cfg_write(CFG_PASS_COUNT, 0);
        cfg_write(CFG_VERTEX_COUNT, 4);
        drive(mk(OPC_LOAD_POS, 0));
        drive('{OPC_LOAD_POS, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        drive('{OPC_LOAD_POS, 1, 7, 1023, 15, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        drive(mk(OPC_LOAD_POS, 2));
        drive(mk(OPC_LOAD_POS, 3));
        drive(mk(OPC_LOAD_POS, 1023));
        drive(mk(OPC_LOAD_NB, 0, 0, 1));
        drive(mk(OPC_LOAD_NB, 0, 1, 2));
        drive(mk(OPC_LOAD_NB, 0, 7, 3));
        drive(mk(OPC_LOAD_NB, 3, 0, 4));
        drive(mk(OPC_LOAD_NB, 5, 0, 0));
        drive(mk(OPC_SET_CNT, 0, 0, 0, 2));
        drive(mk(OPC_SET_CNT, 1, 0, 0, 0));
        drive(mk(OPC_SET_CNT, 2, 0, 0, 9));
        drive(mk(OPC_SET_CNT, 2, 0, 0, 15));
        for (int op = OPC_UNUSED_LO; op <= OPC_UNUSED_HI; op++)
            drive(mk(OPC_W'(op), 0));
        drive(mk(OPC_START, 1023));
        drive(mk(OPC_READ, 0));
        drive(mk(OPC_READ, 1));
        drive(mk(OPC_READ, 1023));
        drain();
        cfg_write(CFG_PASS_COUNT, 1);
        drive(mk(OPC_START, 0));
        drive(mk(OPC_READ, 0));
        drain();
        cfg_write(CFG_VERTEX_COUNT, 2);
        cfg_write(CFG_PASS_COUNT, 255);
        drive(mk(OPC_START, 0));
        drive(mk(OPC_READ, 0));
        drive(mk(OPC_READ, 2));

        // Random meshes; mostly small sizes and few passes.
        while (sent < 1500) begin
            case ($urandom_range(0, 9))
                0:       nv = 0;
                1:       nv = MAXV;
                2:       nv = 2047;
                default: nv = $urandom_range(1, 12);
            endcase
            np = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
            mesh_run(nv, np);
        end

        drain();
        repeat (64) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
design/mnas_pkg.sv
design/mnas_front.sv
design/mnas_divider.sv
design/mnas_back.sv
design/mesh_neighbour_average_smoothing.sv
tb/mesh_neighbour_average_smoothing_tb.sv
